// ===== hdl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared widths, limits and state codes of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int DIGIT_W     = 4;
	localparam int RADIX_W     = 4;
	localparam int STEP_BITS   = 4;
	localparam int DIV_W       = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int STEPS       = DIV_W / STEP_BITS;
	localparam int STEP_CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W       = $clog2(VALUE_WIDTH);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ===== hdl/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts one unsigned integer into its digits in a base from 2 to 10 and
// sends them most significant first, the final digit flagged by last.
// ----------------------------------------------------------------------------
// One value is taken at a time; in_ready is low from the transfer of a value
// until its last digit has been loaded into the output register. Each digit
// comes from a shared divide step that consumes four dividend bits a cycle;
// the digits are then read back from a 31-entry store, one a cycle when the
// output side keeps up. A zero input gives the single digit 0. The radix
// register resets to 10 and a written value outside 2..10 saturates to the
// nearer limit.
module radix_digit_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rdc_pkg::RADIX_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rdc_pkg::VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rdc_pkg::DIGIT_W-1:0]   digit,
	output logic                          last
);
	import rdc_pkg::*;

	state_t                 state_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [DIV_W-1:0]       quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [STEP_CNT_W-1:0]  step_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic                   last_q;

	logic [DIGIT_W-1:0]     store_q [VALUE_WIDTH];

	logic [DIV_W-1:0]       quo_next;
	logic [DIGIT_W-1:0]     rem_next;
	logic [CNT_W-1:0]       count_inc;
	logic [CNT_W-1:0]       count_dec;
	logic                   last_step;
	logic                   div_done;
	logic                   out_free;
	logic                   emit_load;

	always_comb begin
		logic [DIGIT_W:0]      r;
		logic [STEP_BITS-1:0]  qbits;
		r     = '0;
		qbits = '0;
		r[DIGIT_W-1:0] = rem_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[DIGIT_W-1:0], quo_q[DIV_W-1-i]};
			if (r >= {1'b0, radix_q}) begin
				r = r - {1'b0, radix_q};
				qbits[STEP_BITS-1-i] = 1'b1;
			end
		end
		rem_next = r[DIGIT_W-1:0];
		quo_next = {quo_q[DIV_W-STEP_BITS-1:0], qbits};
	end

	assign count_inc = count_q + CNT_W'(1);
	assign count_dec = count_q - CNT_W'(1);
	assign last_step = (step_q == STEP_CNT_W'(STEPS - 1));
	assign div_done  = (quo_next == '0) || (count_inc == CNT_W'(VALUE_WIDTH));
	assign out_free  = !out_valid_q || out_ready;
	assign emit_load = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < RADIX_MIN) begin
				radix_q <= RADIX_MIN;
			end else if (cfg_wdata > RADIX_MAX) begin
				radix_q <= RADIX_MAX;
			end else begin
				radix_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quo_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						quo_q   <= DIV_W'(value);
						rem_q   <= '0;
						step_q  <= '0;
						count_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						count_q <= count_inc;
						quo_q   <= quo_next;
						rem_q   <= '0;
						step_q  <= '0;
						if (div_done) begin
							state_q <= ST_EMIT;
						end
					end else begin
						quo_q  <= quo_next;
						rem_q  <= rem_next;
						step_q <= step_q + STEP_CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= count_dec;
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// store digits, least significant first; read back in reverse
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && last_step) begin
			store_q[count_q[IDX_W-1:0]] <= rem_next;
		end
		if (emit_load) begin
			digit_q <= store_q[count_dec[IDX_W-1:0]];
			last_q  <= (count_q == CNT_W'(1));
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign last      = last_q;

endmodule
